// File: src/pom_pkg.sv
// Package for the perturb-and-observe MPPT block.
// Holds field widths, register indexes and register reset values.
// No dependencies.
package pom_pkg;

  // Field widths
  localparam int unsigned VoltW  = 16;
  localparam int unsigned CurrW  = 16;
  localparam int unsigned PowW   = 32;
  localparam int unsigned StepW  = 10;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_UPDATE_PERIOD = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_STEP_MV       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KICK_MV       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_POWER_THR_UW  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_VREF_MAX_MV   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_VREF_MIN_MV   = 3'd5;

  // Register and state reset values
  localparam logic [15:0]      RST_UPDATE_PERIOD = 16'd5000;
  localparam logic [StepW-1:0] RST_STEP_MV       = 10'd50;
  localparam logic [StepW-1:0] RST_KICK_MV       = 10'd10;
  localparam logic [PowW-1:0]  RST_POWER_THR_UW  = 32'd500000;
  localparam logic [VoltW-1:0] RST_VREF_MAX_MV   = 16'd20000;
  localparam logic [VoltW-1:0] RST_VREF_MIN_MV   = 16'd5000;
  localparam logic [VoltW-1:0] RST_VREF_MV       = 16'd18000;

  // Signed width of the reference adjustment: 16-bit value +/- 10-bit step
  localparam int unsigned AdjW = VoltW + 2;

endpackage

// File: src/pom_if.sv
// Channel interfaces for the perturb-and-observe MPPT block:
// panel sample input, reference output and configuration write.
// Depends on pom_pkg.
interface pom_in_if import pom_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VoltW-1:0] pv_voltage_mv;
  logic [CurrW-1:0] pv_current_ma;

  modport source (output valid, output pv_voltage_mv, output pv_current_ma, input ready);
  modport sink (input valid, input pv_voltage_mv, input pv_current_ma, output ready);
endinterface

interface pom_out_if import pom_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VoltW-1:0] vref_out_mv;

  modport source (output valid, output vref_out_mv, input ready);
  modport sink (input valid, input vref_out_mv, output ready);
endinterface

interface pom_cfg_if import pom_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/perturb_observe_mppt.sv
// Perturb-and-observe maximum power point tracker. One panel sample beat in
// gives one reference voltage beat out, from the output register: the input
// register holds the sample, and the voltage x current product, tick counter,
// tracking decision and clamp all run between it and the output register.
// Both registers advance while the output register is empty or being taken,
// so a sample can be taken on every clock then; throughput is one beat per
// cycle while the output side keeps up. The first sample after reset loads
// the reference with the sampled voltage, unclamped unless it is an update.
// Configuration writes are taken at any time (cfg ready is always high) but
// should be made while no beat is in flight. Depends on pom_pkg and pom_if.
module perturb_observe_mppt
  import pom_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pom_in_if.sink    in_bus,
  pom_out_if.source out_bus,
  pom_cfg_if.sink   cfg_bus
);

  // Configuration registers
  logic [15:0]      period_r;
  logic [StepW-1:0] step_r;
  logic [StepW-1:0] kick_r;
  logic [PowW-1:0]  thr_r;
  logic [VoltW-1:0] vmax_r;
  logic [VoltW-1:0] vmin_r;

  // Tracking state
  logic [15:0]      tick_r,  tick_nxt;
  logic [PowW-1:0]  lpow_r,  lpow_nxt;
  logic [VoltW-1:0] lvolt_r, lvolt_nxt;
  logic [VoltW-1:0] vref_r,  vref_nxt;
  logic             started_r;

  // Pipeline
  logic             s1_vld_r;
  logic [VoltW-1:0] s1_volt_r;
  logic [CurrW-1:0] s1_cur_r;
  logic             out_vld_r;
  logic [VoltW-1:0] out_vref_r;

  logic adv;
  logic in_fire;
  logic s2_fire;
  logic cfg_fire;

  logic [PowW-1:0]        pow;
  logic [16:0]            tick_inc;
  logic                   upd;
  logic [VoltW-1:0]       base;
  logic signed [AdjW-1:0] adj;
  logic signed [AdjW-1:0] clamp_hi;
  logic signed [AdjW-1:0] smax;
  logic signed [AdjW-1:0] smin;
  logic                   dp_pos;
  logic                   dv_pos;

  // Handshake
  assign adv      = !out_vld_r || out_bus.ready;
  assign in_bus.ready = !s1_vld_r || adv;
  assign in_fire  = in_bus.valid && in_bus.ready;
  assign s2_fire  = s1_vld_r && adv;
  assign cfg_bus.ready = 1'b1;
  assign cfg_fire = cfg_bus.valid;

  assign out_bus.valid       = out_vld_r;
  assign out_bus.vref_out_mv = out_vref_r;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= RST_UPDATE_PERIOD;
      step_r   <= RST_STEP_MV;
      kick_r   <= RST_KICK_MV;
      thr_r    <= RST_POWER_THR_UW;
      vmax_r   <= RST_VREF_MAX_MV;
      vmin_r   <= RST_VREF_MIN_MV;
    end else if (cfg_fire) begin
      case (cfg_bus.index)
        REG_UPDATE_PERIOD: period_r <= cfg_bus.data[15:0];
        REG_STEP_MV:       step_r   <= cfg_bus.data[StepW-1:0];
        REG_KICK_MV:       kick_r   <= cfg_bus.data[StepW-1:0];
        REG_POWER_THR_UW:  thr_r    <= cfg_bus.data[PowW-1:0];
        REG_VREF_MAX_MV:   vmax_r   <= cfg_bus.data[VoltW-1:0];
        REG_VREF_MIN_MV:   vmin_r   <= cfg_bus.data[VoltW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: register the sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_volt_r <= in_bus.pv_voltage_mv;
      s1_cur_r  <= in_bus.pv_current_ma;
    end
  end

  // Stage 2: power product, tick counter, P&O decision and clamp
  always_comb begin
    pow      = {16'd0, s1_volt_r} * {16'd0, s1_cur_r};
    tick_inc = {1'b0, tick_r} + 17'd1;
    upd      = tick_inc >= {1'b0, period_r};
    base     = started_r ? vref_r : s1_volt_r;
    dp_pos   = pow > lpow_r;
    dv_pos   = s1_volt_r > lvolt_r;
    smax     = $signed({2'b00, vmax_r});
    smin     = $signed({2'b00, vmin_r});

    if (pow > thr_r) begin
      if (dp_pos == dv_pos) begin
        adj = $signed({2'b00, base}) + $signed({8'd0, step_r});
      end else begin
        adj = $signed({2'b00, base}) - $signed({8'd0, step_r});
      end
    end else begin
      adj = $signed({2'b00, base}) - $signed({8'd0, kick_r});
    end

    // max clamp first, min clamp last
    clamp_hi = (adj > smax) ? smax : adj;

    if (upd) begin
      vref_nxt  = (clamp_hi < smin) ? vmin_r : clamp_hi[VoltW-1:0];
      lpow_nxt  = pow;
      lvolt_nxt = s1_volt_r;
      tick_nxt  = 16'd0;
    end else begin
      vref_nxt  = base;
      lpow_nxt  = lpow_r;
      lvolt_nxt = lvolt_r;
      tick_nxt  = tick_inc[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      lpow_r    <= '0;
      lvolt_r   <= '0;
      vref_r    <= RST_VREF_MV;
      started_r <= 1'b0;
    end else if (s2_fire) begin
      tick_r    <= tick_nxt;
      lpow_r    <= lpow_nxt;
      lvolt_r   <= lvolt_nxt;
      vref_r    <= vref_nxt;
      started_r <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_vref_r <= vref_nxt;
    end
  end

  // Checks
  a_min_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && upd |-> vref_nxt >= vmin_r)
    else $error("reference below lower limit after update");

  a_max_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire && upd && (vmin_r <= vmax_r) |-> vref_nxt <= vmax_r)
    else $error("reference above upper limit after update");

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    s2_fire |=> (tick_r == 16'd0) || (tick_r == $past(tick_r) + 16'd1))
    else $error("tick counter jumped");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> s1_vld_r && out_vld_r && !out_bus.ready)
    else $error("input stalled with room in the pipeline");

  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(s1_vld_r))
    else $error("result beat without a stage 1 beat");

endmodule
